// File: hdl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the pipelined signed integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam mode_t OP_ADD = mode_t'(0);
  localparam mode_t OP_SUB = mode_t'(1);
  localparam mode_t OP_MUL = mode_t'(2);
  localparam mode_t OP_DIV = mode_t'(3);
  localparam mode_t OP_REM = mode_t'(4);

  localparam status_t ST_OK      = status_t'(0);
  localparam status_t ST_BADOP   = status_t'(1);
  localparam status_t ST_DIVZERO = status_t'(2);

  // Payload carried down the divider pipeline
  typedef struct packed {
    mode_t mode;
    logic  neg_q;   // quotient must be negated
    logic  neg_r;   // remainder must be negated
    logic  bzero;   // divisor is zero
    word_t alt;     // add / sub / mul result
    word_t mb;      // divisor magnitude
    word_t rem;     // partial remainder
    word_t quo;     // dividend bits shifting out, quotient bits shifting in
  } stage_t;

endpackage

`default_nettype wire

// File: hdl/integer_alu_add_sub_mul_div_rem_core.sv
// An accepted input passes the front-stage register, the divider stages and the output register to out_.
// Throughput: one transaction per cycle while out_ is not stalled; the 32 one-bit divider stages set the depth.
// Every operation runs the same pipeline, so results leave in input order.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low.
// Reset: synchronous, active low, clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// integer_alu_add_sub_mul_div_rem_core
// Signed 32-bit ALU: add, subtract, multiply low word, divide, remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_alu_add_sub_mul_div_rem_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  wire  [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // [31:0] result, [33:32] status, rest zero
);
  import ialu_pkg::*;

  localparam int unsigned NSTEP = DATA_W;

  logic    en;
  mode_t   mode_in;
  word_t   a_in;
  word_t   b_in;
  word_t   alt_nxt;
  logic    na, nb;

  logic              s1_valid_r;
  stage_t            s1_r;
  stage_t            s1_nxt;

  logic   [NSTEP:0]  pv;
  stage_t            ps [NSTEP+1];

  logic              out_valid_r;
  word_t             res_r;
  word_t             res_nxt;
  status_t           st_r;
  status_t           st_nxt;
  stage_t            fin;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign mode_in   = in_tuser;
  assign a_in      = in_tdata[DATA_W-1:0];
  assign b_in      = in_tdata[2*DATA_W-1:DATA_W];
  assign na        = a_in[DATA_W-1];
  assign nb        = b_in[DATA_W-1];

  // front stage: add/sub/mul and operand magnitudes
  always_comb begin
    case (mode_in)
      OP_ADD:  alt_nxt = a_in + b_in;
      OP_SUB:  alt_nxt = a_in - b_in;
      default: alt_nxt = a_in * b_in;
    endcase
    s1_nxt.mode  = mode_in;
    s1_nxt.neg_q = na ^ nb;
    s1_nxt.neg_r = na;
    s1_nxt.bzero = (b_in == '0);
    s1_nxt.alt   = alt_nxt;
    s1_nxt.mb    = nb ? (~b_in + 1'b1) : b_in;
    s1_nxt.rem   = '0;
    s1_nxt.quo   = na ? (~a_in + 1'b1) : a_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign pv[0] = s1_valid_r;
  assign ps[0] = s1_r;

  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    ialu_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pv[i]),
      .in_stage  (ps[i]),
      .out_valid (pv[i+1]),
      .out_stage (ps[i+1])
    );
  end

  // final select
  always_comb begin
    fin     = ps[NSTEP];
    res_nxt = '0;
    st_nxt  = ST_OK;
    case (fin.mode)
      OP_ADD, OP_SUB, OP_MUL: res_nxt = fin.alt;
      OP_DIV: begin
        if (fin.bzero) begin
          st_nxt = ST_DIVZERO;
        end else begin
          res_nxt = fin.neg_q ? (~fin.quo + 1'b1) : fin.quo;
        end
      end
      OP_REM: begin
        if (fin.bzero) begin
          st_nxt = ST_DIVZERO;
        end else begin
          res_nxt = fin.neg_r ? (~fin.rem + 1'b1) : fin.rem;
        end
      end
      default: st_nxt = ST_BADOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, st_r, res_r};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (st_r != ST_OK)) |-> (res_r == '0))
    else $error("error status with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r == ST_OK || st_r == ST_BADOP || st_r == ST_DIVZERO))
    else $error("undefined status code");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(pv) && $stable(s1_valid_r)))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: hdl/ialu_div_step.sv
// ----------------------------------------------------------------------------
// ialu_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_div_step (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_valid,
  input  ialu_pkg::stage_t     in_stage,
  output logic                 out_valid,
  output ialu_pkg::stage_t     out_stage
);
  import ialu_pkg::*;

  logic              valid_r;
  stage_t            stage_r;
  stage_t            stage_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              take;

  always_comb begin
    rem_sh    = {in_stage.rem, in_stage.quo[DATA_W-1]};
    diff      = rem_sh - {1'b0, in_stage.mb};
    take      = !diff[DATA_W];
    stage_nxt = in_stage;
    stage_nxt.rem = take ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    stage_nxt.quo = {in_stage.quo[DATA_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire

// File: tb/integer_alu_add_sub_mul_div_rem_core_test.sv
// ----------------------------------------------------------------------------
// integer_alu_add_sub_mul_div_rem_core_test
// Drives add/sub/mul/div/rem transactions (directed table, then random) into
// the ALU core under random valid/ready idling and checks every result and
// status against the typed expectation or an internal predictor, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_alu_add_sub_mul_div_rem_core_test;
  import ialu_pkg::*;

  localparam int LATENCY     = 34;
  localparam int N_RANDOM    = 1430;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    mode_t   mode;
    word_t   a;
    word_t   b;
    logic    known;   // expected result typed in
    word_t   res;
    status_t st;
  } vec_t;

  typedef struct packed {
    word_t   res;
    status_t st;
  } alu_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  alu_out_t expected_q[$];
  int       err_count;
  int       cycle_count;
  int       src_idle_pct;
  int       snk_idle_pct;

  integer_alu_add_sub_mul_div_rem_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic word_t neg_w(word_t x);
    return ~x + word_t'(1);
  endfunction

  function automatic alu_out_t alu_compute(mode_t mode, word_t a, word_t b);
    alu_out_t o;
    word_t    ma;
    word_t    mb;
    o = '0;
    o.st = ST_OK;
    case (mode)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: o.res = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          o.st = ST_DIVZERO;
        end else begin
          ma = a[DATA_W-1] ? neg_w(a) : a;
          mb = b[DATA_W-1] ? neg_w(b) : b;
          if (mode == OP_DIV)
            o.res = (a[DATA_W-1] != b[DATA_W-1]) ? neg_w(ma / mb) : ma / mb;
          else
            o.res = a[DATA_W-1] ? neg_w(ma % mb) : ma % mb;
        end
      end
      default: o.st = ST_BADOP;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Send one transaction; holds valid until accepted, idles at random after.
  task automatic send_op(mode_t mode, word_t a, word_t b);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sink: ready toggles, check on each accepted result.
  always @(posedge clk) begin
    alu_out_t got;
    alu_out_t want;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_tvalid && out_tready) begin
        got.res = out_tdata[31:0];
        got.st  = out_tdata[33:32];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (got.res !== want.res) report_mismatch("result", got.res, want.res);
          if (got.st !== want.st)   report_mismatch("status", 32'(got.st), 32'(want.st));
          if (out_tdata[39:34] !== 6'd0)
            report_mismatch("pad bits", 32'(out_tdata[39:34]), 32'h0);
        end
      end
      out_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic run_vec(vec_t v);
    alu_out_t p;
    p = alu_compute(v.mode, v.a, v.b);
    if (v.known && (p.res !== v.res || p.st !== v.st))
      report_mismatch("directed table", p.res, v.res);
    expected_q.push_back(v.known ? alu_out_t'({v.res, v.st}) : p);
    send_op(v.mode, v.a, v.b);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return word_t'($urandom_range(15));
      1: return neg_w(word_t'($urandom_range(16)));
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return word_t'($urandom);
    endcase
  endfunction

  localparam word_t MIN_W = 32'h8000_0000;
  localparam word_t MAX_W = 32'h7fff_ffff;
  localparam word_t M1_W  = 32'hffff_ffff;

  vec_t directed[] = '{
    '{OP_ADD, MAX_W, 32'd1,  1'b1, MIN_W,        ST_OK},
    '{OP_ADD, M1_W,  M1_W,   1'b1, 32'hffff_fffe, ST_OK},
    '{OP_SUB, MIN_W, 32'd1,  1'b1, MAX_W,        ST_OK},
    '{OP_SUB, 32'd0, MIN_W,  1'b1, MIN_W,        ST_OK},
    '{OP_MUL, MAX_W, MAX_W,  1'b1, 32'd1,        ST_OK},
    '{OP_MUL, MIN_W, M1_W,   1'b1, MIN_W,        ST_OK},
    '{OP_MUL, 32'h0001_2345, 32'hfedc_ba98, 1'b0, 32'd0, ST_OK},
    '{OP_DIV, MIN_W, M1_W,   1'b1, MIN_W,        ST_OK},
    '{OP_REM, MIN_W, M1_W,   1'b1, 32'd0,        ST_OK},
    '{OP_DIV, 32'd7, 32'd0,  1'b1, 32'd0,        ST_DIVZERO},
    '{OP_REM, MIN_W, 32'd0,  1'b1, 32'd0,        ST_DIVZERO},
    '{OP_DIV, neg_w(32'd7), 32'd2, 1'b1, neg_w(32'd3), ST_OK},
    '{OP_REM, neg_w(32'd7), 32'd2, 1'b1, M1_W,   ST_OK},
    '{OP_DIV, 32'd7, neg_w(32'd2), 1'b1, neg_w(32'd3), ST_OK},
    '{OP_REM, 32'd7, neg_w(32'd2), 1'b1, 32'd1,  ST_OK},
    '{OP_DIV, MAX_W, MIN_W,  1'b1, 32'd0,        ST_OK},
    '{OP_REM, MAX_W, MIN_W,  1'b1, MAX_W,        ST_OK},
    '{OP_DIV, MIN_W, MIN_W,  1'b0, 32'd0,        ST_OK},
    '{OP_REM, 32'h1234_5678, 32'h0000_0123, 1'b0, 32'd0, ST_OK},
    '{mode_t'(5), MAX_W, 32'd3, 1'b1, 32'd0,     ST_BADOP},
    '{mode_t'(6), MIN_W, 32'd0, 1'b1, 32'd0,     ST_BADOP},
    '{mode_t'(7), M1_W,  M1_W,  1'b1, 32'd0,     ST_BADOP}
  };

  initial begin
    vec_t v;
    int   drain;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    err_count    = 0;
    cycle_count  = 0;
    src_idle_pct = 23;
    snk_idle_pct = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) run_vec(directed[i]);

    // Hold off until the pipeline has drained completely.
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        src_idle_pct = 59;
        snk_idle_pct = 23;
      end else if (n == 2 * N_RANDOM / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      v       = '0;
      v.mode  = ($urandom_range(9) == 0) ? mode_t'($urandom_range(7, 5))
                                         : mode_t'($urandom_range(4));
      v.a     = rand_word();
      v.b     = ($urandom_range(15) == 0) ? word_t'(0) : rand_word();
      run_vec(v);
    end
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 4 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
